// File: sv/idc_pkg.sv
// package for the identifier grammar checker
// shared grammar codes, register indexes and the byte class and result structs
// no dependencies
`default_nettype none

package idc_pkg;

   typedef enum logic [1:0] {
      GRAM_ORG     = 2'd0,
      GRAM_VENUE   = 2'd1,
      GRAM_INSTR   = 2'd2,
      GRAM_ADAPTER = 2'd3
   } grammar_type;

   typedef enum logic [1:0] {
      CSR_GRAMMAR       = 2'd0,
      CSR_PREFIX_BYTES  = 2'd1,
      CSR_PREFIX_LENGTH = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   // most prefix bytes honoured, longer settings are clipped to this
   localparam logic [3:0] PREFIX_MAX_BYTES = 4'd8;

   typedef struct packed {
      logic in_prefix;     // byte falls inside the organisation prefix
      logic prefix_match;  // byte equals the expected prefix byte
      logic free_form;     // adapter grammar, no separator rules
      logic is_sep;        // separator of the current grammar
      logic is_data;       // legal data byte of the current grammar
   } byte_class_type;

   typedef struct packed {
      logic [6:0] byte_count;
      logic       accepted;
   } result_type;

endpackage

`default_nettype wire

// File: sv/identifier_grammar_checker.sv
// identifier grammar checker, top level
// a request is held in the input register, and a last byte then loads its verdict into the result
//    register that drives rsp_tvalid
// throughput: one byte per cycle, counter and flags being updated for each byte;
//    a last byte waits in the input register while an untaken verdict fills the result register
// reset: synchronous, clears input valid, stream state, result valid and registers (organisation, no prefix)
// depends on idc_pkg, idc_classify, idc_tracker
`default_nettype none

module identifier_grammar_checker #(
   parameter int ORG_MAX_LEN     = 64,
   parameter int VENUE_MAX_LEN   = 64,
   parameter int INSTR_MAX_LEN   = 64,
   parameter int ADAPTER_MAX_LEN = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic        req_tlast,   // is_last
   input  wire logic        req_tuser,   // [0] no_character
   // verdict stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] accepted, [7:1] byte_count
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import idc_pkg::*;

   // largest limit sets the counter width, which must hold limit plus one
   localparam int MAX_A   = (ORG_MAX_LEN > VENUE_MAX_LEN) ? ORG_MAX_LEN : VENUE_MAX_LEN;
   localparam int MAX_B   = (INSTR_MAX_LEN > ADAPTER_MAX_LEN) ? INSTR_MAX_LEN : ADAPTER_MAX_LEN;
   localparam int MAX_LEN = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int CNT_RAW = $clog2(MAX_LEN + 2);
   // at least seven bits so the reported count is a plain part-select
   localparam int CNT_W   = (CNT_RAW > 7) ? CNT_RAW : 7;

   // configuration registers
   grammar_type grammar_ff;
   logic [63:0] prefix_bytes_ff;
   logic [3:0]  prefix_length_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic        s1_last_ff;
   logic        s1_none_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   logic             req_take;
   logic             advance;
   logic [CNT_W-1:0] limit;
   logic [CNT_W-1:0] count;
   byte_class_type   byte_class;
   result_type       result;

   // register writes are always taken, unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grammar_ff       <= GRAM_ORG;
         prefix_bytes_ff  <= '0;
         prefix_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_GRAMMAR:       grammar_ff       <= grammar_type'(csr_wdata[1:0]);
            CSR_PREFIX_BYTES:  prefix_bytes_ff  <= csr_wdata;
            CSR_PREFIX_LENGTH: prefix_length_ff <= csr_wdata[3:0];
            default: begin
               grammar_ff <= grammar_ff;
            end
         endcase
      end
   end

   // length limit of the grammar in force
   always_comb begin
      case (grammar_ff)
         GRAM_ORG:     limit = CNT_W'(ORG_MAX_LEN);
         GRAM_VENUE:   limit = CNT_W'(VENUE_MAX_LEN);
         GRAM_INSTR:   limit = CNT_W'(INSTR_MAX_LEN);
         GRAM_ADAPTER: limit = CNT_W'(ADAPTER_MAX_LEN);
         default:      limit = CNT_W'(ADAPTER_MAX_LEN);
      endcase
   end

   // a held byte moves on unless it is last and the result register is still full
   assign advance    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
         s1_none_ff <= req_tuser;
      end
   end

   idc_classify #(
      .CNT_W (CNT_W)
   ) u_classify (
      .character     (s1_char_ff),
      .grammar       (grammar_ff),
      .prefix_bytes  (prefix_bytes_ff),
      .prefix_length (prefix_length_ff),
      .position      (count),
      .byte_class    (byte_class)
   );

   idc_tracker #(
      .CNT_W (CNT_W)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .no_character (s1_none_ff),
      .is_last      (s1_last_ff),
      .byte_class   (byte_class),
      .limit        (limit),
      .count        (count),
      .result       (result)
   );

   // verdict register, loaded only by a last byte
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a verdict only appears after a last byte went through
   a_rsp_from_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && s1_last_ff))
      else $error("verdict appeared without a last byte");

   // stream state is cleared once the last byte is consumed
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (count == '0))
      else $error("byte counter not cleared after last byte");

   // counter never goes beyond the largest limit plus one
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(MAX_LEN + 1))
      else $error("byte counter beyond saturation point");

   // a full result register that is not drained blocks a waiting last byte
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && s1_valid_ff && s1_last_ff) |-> !advance)
      else $error("verdict overwritten before it was taken");

endmodule

`default_nettype wire

// File: sv/idc_classify.sv
// byte classifier for the identifier grammar checker
// sorts one byte into prefix, separator or data classes for the chosen grammar
// depends on idc_pkg
`default_nettype none

module idc_classify #(
   parameter int CNT_W = 7
) (
   input  wire logic [7:0]              character,
   input  wire idc_pkg::grammar_type    grammar,
   input  wire logic [63:0]             prefix_bytes,
   input  wire logic [3:0]              prefix_length,
   input  wire logic [CNT_W-1:0]        position,
   output idc_pkg::byte_class_type      byte_class
);
   import idc_pkg::*;

   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7a;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7e;

   logic       is_digit;
   logic       lower_an;
   logic       upper_an;
   logic       printable;
   logic [3:0] plen;
   logic [7:0] want;

   always_comb begin
      is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
      lower_an  = ((character >= CH_LO_A) && (character <= CH_LO_Z)) || is_digit;
      upper_an  = ((character >= CH_UP_A) && (character <= CH_UP_Z)) || is_digit;
      printable = (character >= CH_SPACE) && (character <= CH_TILDE);
      plen      = (prefix_length > PREFIX_MAX_BYTES) ? PREFIX_MAX_BYTES : prefix_length;
      want      = prefix_bytes[{position[2:0], 3'b000} +: 8];
   end

   always_comb begin
      byte_class              = '0;
      byte_class.prefix_match = (character == want);
      case (grammar)
         GRAM_ORG: begin
            byte_class.in_prefix = (position < CNT_W'(plen));
            byte_class.is_sep    = (character == CH_DOT) || (character == CH_DASH);
            byte_class.is_data   = lower_an;
         end
         GRAM_VENUE: begin
            byte_class.is_sep  = (character == CH_DASH);
            byte_class.is_data = lower_an;
         end
         GRAM_INSTR: begin
            byte_class.is_sep  = (character == CH_DASH);
            byte_class.is_data = upper_an;
         end
         GRAM_ADAPTER: begin
            byte_class.free_form = 1'b1;
            byte_class.is_data   = printable;
         end
         default: begin
            byte_class.is_data = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/idc_tracker.sv
// stream state for the identifier grammar checker
// holds the byte counter and grammar flags, and forms the verdict on the last byte
// depends on idc_pkg
`default_nettype none

module idc_tracker #(
   parameter int CNT_W = 7
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    no_character,
   input  wire logic                    is_last,
   input  wire idc_pkg::byte_class_type byte_class,
   input  wire logic [CNT_W-1:0]        limit,
   output logic [CNT_W-1:0]             count,
   output idc_pkg::result_type          result
);
   import idc_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in, count_next;
   logic             last_data_ff, last_data_in, last_data_next;
   logic             rejected_ff, rejected_in, rejected_next;
   logic [CNT_W-1:0] limit_p1;

   assign count = count_ff;

   always_comb begin
      limit_p1       = limit + CNT_W'(1);
      count_next     = count_ff;
      last_data_next = last_data_ff;
      rejected_next  = rejected_ff;
      if (!no_character) begin
         count_next = (count_ff < limit_p1) ? count_ff + CNT_W'(1) : limit_p1;
         if (byte_class.in_prefix) begin
            rejected_next  = rejected_ff | ~byte_class.prefix_match;
            last_data_next = 1'b0;
         end else if (byte_class.free_form) begin
            rejected_next  = rejected_ff | ~byte_class.is_data;
            last_data_next = 1'b1;
         end else if (byte_class.is_sep) begin
            // a separator must follow a data byte
            rejected_next  = rejected_ff | ~last_data_ff;
            last_data_next = 1'b0;
         end else if (byte_class.is_data) begin
            last_data_next = 1'b1;
         end else begin
            rejected_next  = 1'b1;
            last_data_next = 1'b0;
         end
      end
   end

   always_comb begin
      result.accepted   = !rejected_next && last_data_next &&
                          (count_next != '0) && (count_next <= limit);
      result.byte_count = count_next[6:0];
   end

   always_comb begin
      count_in     = count_ff;
      last_data_in = last_data_ff;
      rejected_in  = rejected_ff;
      if (step) begin
         if (is_last) begin
            count_in     = '0;
            last_data_in = 1'b0;
            rejected_in  = 1'b0;
         end else begin
            count_in     = count_next;
            last_data_in = last_data_next;
            rejected_in  = rejected_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_data_ff <= 1'b0;
         rejected_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_data_ff <= last_data_in;
         rejected_ff  <= rejected_in;
      end
   end

endmodule

`default_nettype wire
